@@ hdl/ffpa_pkg.sv @@
// Shared types and constants for the first-fit page range allocator.
// No dependencies; the core and ffpa_cmp import this package.
package ffpa_pkg;

  localparam int unsigned MaxRangesDef = 64;
  localparam int unsigned PageBitsDef  = 20;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_MARK    = 2'd1,
    OP_UNMARK  = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_OVERLAP  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  localparam logic CfgLowPage  = 1'b0;
  localparam logic CfgHighPage = 1'b1;

  // Flags the compare unit derives from one stored range.
  typedef struct packed {
    logic end_le_cand;  // range ends at or before the reserve candidate
    logic gap_fits;     // range starts at least count pages past the candidate
    logic overlaps;     // range intersects the mark range
    logic start_ge;     // range starts at or after the mark start
    logic same_range;   // range equals the unmark range
    logic contains;     // range holds the release page
  } cmp_flags_t;

endpackage

@@ hdl/ffpa_if.sv @@
// Request and response channel interfaces of the allocator.
// Depends on nothing; widths follow the page_bits parameter.
interface ffpa_req_if #(parameter int unsigned PAGE_BITS = 20);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [PAGE_BITS:0]   page_count;
  logic [PAGE_BITS-1:0] start_page;
  logic [PAGE_BITS:0]   end_page;

  modport source (output valid, opcode, page_count, start_page, end_page, input ready);
  modport sink   (input valid, opcode, page_count, start_page, end_page, output ready);
endinterface

interface ffpa_rsp_if #(parameter int unsigned PAGE_BITS = 20);
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [PAGE_BITS-1:0] result_page;

  modport source (output valid, status, result_page, input ready);
  modport sink   (input valid, status, result_page, output ready);
endinterface

@@ hdl/first_fit_page_range_allocator_core.sv @@
// Top level of the first-fit page range allocator: sequencer, config registers.
// Depends on ffpa_pkg, ffpa_if, ffpa_table and ffpa_cmp.
//
//   channel | direction | transfer when         | payload
//   req     | in        | req.valid & req.ready | opcode, page_count, start_page, end_page
//   rsp     | out       | rsp.valid & rsp.ready | status, result_page
//   cfg     | in        | cfg_we_i              | cfg_idx_i selects low/high page
//
// An operation scans the stored ranges one at a time (a read state and an evaluate
// state per range), then moves entries one at a time for an insert or remove.
// The table's single read port sets this pace.
// Reset empties the table at once; no clearing pass is needed.
// req.ready is low while an operation runs; a finished result waits in the
// output register while the next request is taken.
module first_fit_page_range_allocator_core #(
  parameter int unsigned MAX_RANGES = ffpa_pkg::MaxRangesDef,
  parameter int unsigned PAGE_BITS  = ffpa_pkg::PageBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ffpa_req_if.sink             req,
  ffpa_rsp_if.source           rsp,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [PAGE_BITS-1:0] cfg_wdata_i
);
  import ffpa_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned W  = PAGE_BITS + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_RANGES);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD, S_EV, S_FIT, S_INS_RD, S_INS_WR, S_REM_RD, S_REM_WR, S_DONE
  } state_e;

  state_e               state_q;
  op_e                  op_q;
  logic [W-1:0]         cnt_q;
  logic [PAGE_BITS-1:0] s_q;
  logic [W-1:0]         e_q;
  logic [W-1:0]         cand_q;
  logic [CW-1:0]        k_q;
  logic [CW-1:0]        pos_q;
  logic [CW-1:0]        tab_cnt_q;
  logic [PAGE_BITS-1:0] nstart_q;
  logic [W-1:0]         nend_q;
  status_e              st_q;
  logic [PAGE_BITS-1:0] pg_q;
  logic [PAGE_BITS-1:0] low_q;
  logic [PAGE_BITS-1:0] high_q;
  logic                 rsp_valid_q;
  logic [2:0]           rsp_status_q;
  logic [PAGE_BITS-1:0] rsp_page_q;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [PAGE_BITS-1:0] wstart;
  logic [W-1:0]         wend;
  logic [AW-1:0]        raddr;
  logic [PAGE_BITS-1:0] rstart;
  logic [W-1:0]         rend;
  cmp_flags_t           flags;

  logic [W-1:0]         limit;
  logic [W:0]           fit_end;
  logic                 tail_short;

  assign limit      = {1'b0, high_q} + W'(1);
  assign fit_end    = {1'b0, cand_q} + {1'b0, cnt_q};
  assign tail_short = (cand_q >= limit) || ((limit - cand_q) < cnt_q);

  ffpa_table #(.MAX_RANGES(MAX_RANGES), .PAGE_BITS(PAGE_BITS)) u_table (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wstart_i (wstart),
    .wend_i   (wend),
    .raddr_i  (raddr),
    .rstart_o (rstart),
    .rend_o   (rend)
  );

  ffpa_cmp #(.PAGE_BITS(PAGE_BITS)) u_cmp (
    .rstart_i (rstart),
    .rend_i   (rend),
    .cand_i   (cand_q),
    .count_i  (cnt_q),
    .start_i  (s_q),
    .end_i    (e_q),
    .flags_o  (flags)
  );

  always_comb begin
    we     = 1'b0;
    waddr  = k_q[AW-1:0];
    wstart = rstart;
    wend   = rend;
    raddr  = k_q[AW-1:0];
    case (state_q)
      S_INS_RD: begin
        raddr = AW'(k_q - CW'(1));
        if (k_q == pos_q) begin
          we     = 1'b1;
          wstart = nstart_q;
          wend   = nend_q;
        end
      end
      S_INS_WR: we = 1'b1;
      S_REM_RD: raddr = AW'(k_q + CW'(1));
      S_REM_WR: we = 1'b1;
      default: ;
    endcase
  end

  assign req.ready       = (state_q == S_IDLE);
  assign rsp.valid       = rsp_valid_q;
  assign rsp.status      = rsp_status_q;
  assign rsp.result_page = rsp_page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= PAGE_BITS'(786432);
      high_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLowPage:  low_q  <= cfg_wdata_i;
        CfgHighPage: high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tab_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            op_q    <= op_e'(req.opcode);
            cnt_q   <= req.page_count;
            s_q     <= req.start_page;
            e_q     <= req.end_page;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          k_q    <= '0;
          pos_q  <= tab_cnt_q;
          cand_q <= {1'b0, low_q};
          pg_q   <= '0;
          state_q <= S_RD;
          case (op_q)
            OP_RESERVE: begin
              if (tab_cnt_q >= MaxCnt) begin
                st_q <= ST_FULL;
                state_q <= S_DONE;
              end else if (cnt_q == '0 || low_q > high_q) begin
                st_q <= ST_NOSPACE;
                state_q <= S_DONE;
              end
            end
            OP_MARK: begin
              if (e_q <= {1'b0, s_q} || (e_q[PAGE_BITS] && |e_q[PAGE_BITS-1:0])) begin
                st_q <= ST_OVERLAP;
                state_q <= S_DONE;
              end
            end
            default: ;
          endcase
        end
        S_RD: begin
          if (k_q == tab_cnt_q) begin
            state_q <= S_DONE;
            case (op_q)
              OP_RESERVE: begin
                if (tail_short) begin
                  st_q <= ST_NOSPACE;
                end else begin
                  pos_q   <= tab_cnt_q;
                  state_q <= S_FIT;
                end
              end
              OP_MARK: begin
                if (tab_cnt_q >= MaxCnt) begin
                  st_q <= ST_FULL;
                end else begin
                  nstart_q <= s_q;
                  nend_q   <= e_q;
                  st_q     <= ST_OK;
                  k_q      <= tab_cnt_q;
                  state_q  <= S_INS_RD;
                end
              end
              default: st_q <= ST_NOTFOUND;
            endcase
          end else begin
            state_q <= S_EV;
          end
        end
        S_EV: begin
          k_q     <= k_q + CW'(1);
          state_q <= S_RD;
          case (op_q)
            OP_RESERVE: begin
              if (!flags.end_le_cand) begin
                if (flags.gap_fits) begin
                  pos_q   <= k_q;
                  state_q <= S_FIT;
                end else begin
                  cand_q <= rend;
                end
              end
            end
            OP_MARK: begin
              if (flags.overlaps) begin
                st_q    <= ST_OVERLAP;
                state_q <= S_DONE;
              end else if (flags.start_ge && pos_q == tab_cnt_q) begin
                pos_q <= k_q;
              end
            end
            OP_UNMARK: begin
              if (flags.same_range) begin
                st_q    <= ST_OK;
                k_q     <= k_q;
                state_q <= S_REM_RD;
              end
            end
            default: begin
              if (flags.contains) begin
                st_q    <= ST_OK;
                k_q     <= k_q;
                state_q <= S_REM_RD;
              end
            end
          endcase
        end
        S_FIT: begin
          if (fit_end > {1'b0, limit}) begin
            st_q    <= ST_NOSPACE;
            state_q <= S_DONE;
          end else begin
            nstart_q <= cand_q[PAGE_BITS-1:0];
            nend_q   <= fit_end[W-1:0];
            pg_q     <= cand_q[PAGE_BITS-1:0];
            st_q     <= ST_OK;
            k_q      <= tab_cnt_q;
            state_q  <= S_INS_RD;
          end
        end
        S_INS_RD: begin
          if (k_q == pos_q) begin
            tab_cnt_q <= tab_cnt_q + CW'(1);
            state_q   <= S_DONE;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          k_q     <= k_q - CW'(1);
          state_q <= S_INS_RD;
        end
        S_REM_RD: begin
          if (k_q + CW'(1) >= tab_cnt_q) begin
            tab_cnt_q <= tab_cnt_q - CW'(1);
            state_q   <= S_DONE;
          end else begin
            state_q <= S_REM_WR;
          end
        end
        S_REM_WR: begin
          k_q     <= k_q + CW'(1);
          state_q <= S_REM_RD;
        end
        S_DONE: begin
          // hold the result until the output register frees up
          if (!rsp_valid_q || rsp.ready) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= st_q;
            rsp_page_q   <= pg_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_cnt_q <= MaxCnt)
    else $error("range count exceeds table depth");

  a_page_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_page_q != '0) |-> (rsp_status_q == ST_OK))
    else $error("nonzero result page with failing status");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while an operation is starting");

  a_write_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_INS_RD || state_q == S_INS_WR || state_q == S_REM_WR))
    else $error("table write outside insert or remove");
endmodule

@@ hdl/ffpa_table.sv @@
// Range table memory: one write port, one read port with registered data.
// Depends on ffpa_pkg only by convention; entries hold {end, start}.
module ffpa_table #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned PAGE_BITS  = 20,
  localparam int unsigned AW = $clog2(MAX_RANGES)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [PAGE_BITS-1:0] wstart_i,
  input  logic [PAGE_BITS:0]   wend_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [PAGE_BITS-1:0] rstart_o,
  output logic [PAGE_BITS:0]   rend_o
);
  logic [2*PAGE_BITS:0] mem_q [MAX_RANGES];
  logic [2*PAGE_BITS:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wend_i, wstart_i};
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rstart_o = rdata_q[PAGE_BITS-1:0];
  assign rend_o   = rdata_q[2*PAGE_BITS:PAGE_BITS];
endmodule

@@ hdl/ffpa_cmp.sv @@
// Shared compare unit: evaluates one stored range against the operands.
// Depends on ffpa_pkg for the flag struct.
module ffpa_cmp #(
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic [PAGE_BITS-1:0]  rstart_i,
  input  logic [PAGE_BITS:0]    rend_i,
  input  logic [PAGE_BITS:0]    cand_i,
  input  logic [PAGE_BITS:0]    count_i,
  input  logic [PAGE_BITS-1:0]  start_i,
  input  logic [PAGE_BITS:0]    end_i,
  output ffpa_pkg::cmp_flags_t  flags_o
);
  import ffpa_pkg::*;

  logic [PAGE_BITS:0] rs_ext;
  logic [PAGE_BITS:0] s_ext;
  logic [PAGE_BITS:0] gap;

  assign rs_ext = {1'b0, rstart_i};
  assign s_ext  = {1'b0, start_i};
  assign gap    = rs_ext - cand_i;

  always_comb begin
    flags_o.end_le_cand = (rend_i <= cand_i);
    flags_o.gap_fits    = (rs_ext >= cand_i) && (gap >= count_i);
    flags_o.overlaps    = (rs_ext < end_i) && (s_ext < rend_i);
    flags_o.start_ge    = (rs_ext >= s_ext);
    flags_o.same_range  = (rstart_i == start_i) && (rend_i == end_i);
    flags_o.contains    = (rs_ext <= s_ext) && (s_ext < rend_i);
  end
endmodule
